### rtl/core/ipv6lv_pkg.sv
package ipv6lv_pkg;

  localparam int QUEUE_DEPTH  = 2;
  localparam int OCTET_MAX    = 255;
  localparam int MAX_GROUPS   = 8;
  localparam int GROUP_DIGITS = 4;
  localparam int GROUP_SAT    = 15;
  localparam int OCTET_DIGITS = 3;
  localparam int IPV4_OCTETS  = 3;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_HEX_ALPHA,
    CC_COLON,
    CC_DOT,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } word_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_HEX,
    PH_IPV4
  } phase_t;

  function automatic word_t classify(input logic [7:0] b, input logic last);
    word_t w;
    w.last  = last;
    w.digit = 4'(b - 8'h30);
    if (b >= 8'h30 && b <= 8'h39) begin
      w.cls = CC_DIGIT;
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      w.cls = CC_HEX_ALPHA;
    end else if (b == 8'h3a) begin
      w.cls = CC_COLON;
    end else if (b == 8'h2e) begin
      w.cls = CC_DOT;
    end else begin
      w.cls = CC_OTHER;
    end
    return w;
  endfunction

endpackage

### rtl/core/ipv6lv_front.sv
module ipv6lv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              f_valid,
  input  logic              f_ready,
  output ipv6lv_pkg::word_t f_word
);

  logic take;

  assign in_ready = !f_valid || f_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  // classified word register
  always_ff @(posedge clk) begin
    if (take) begin
      f_word <= ipv6lv_pkg::classify(byte_value, last_byte);
    end
  end

endmodule

### rtl/core/ipv6lv_queue.sv
module ipv6lv_queue #(
  parameter int Depth = ipv6lv_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  ipv6lv_pkg::word_t          push_word,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output ipv6lv_pkg::word_t          pop_word,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ipv6lv_pkg::word_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            push;
  logic            pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

### rtl/core/ipv6lv_back.sv
module ipv6lv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  ipv6lv_pkg::word_t q_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              literal_valid
);

  ipv6lv_pkg::phase_t phase, phase_next;
  logic       failed, failed_next;
  logic [3:0] group_count, group_count_next;
  logic       compression_seen, compression_seen_next;
  logic [1:0] leading_colons, leading_colons_next;
  logic       pending_colon, pending_colon_next;
  logic [2:0] hex_digit_count, hex_digit_count_next;
  logic       segment_all_decimal, segment_all_decimal_next;
  logic [7:0] octet_value, octet_value_next;
  logic [1:0] octet_digit_count, octet_digit_count_next;
  logic       octet_leading_zero, octet_leading_zero_next;
  logic [1:0] octet_index, octet_index_next;

  logic        pop;
  logic        hex_step;
  logic        is_hex;
  logic        group_start;
  logic [7:0]  mul_src;
  logic [11:0] octet_acc;
  logic        octet_over;
  logic [4:0]  groups;
  logic        verdict;

  assign q_ready = !q_word.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  assign is_hex      = q_word.cls == ipv6lv_pkg::CC_DIGIT ||
                       q_word.cls == ipv6lv_pkg::CC_HEX_ALPHA;
  assign hex_step    = phase == ipv6lv_pkg::PH_HEX ||
                       (phase == ipv6lv_pkg::PH_START && leading_colons == 2'd0 &&
                        q_word.cls != ipv6lv_pkg::CC_COLON);
  assign group_start = hex_step && hex_digit_count == 3'd0;
  assign mul_src     = group_start ? 8'd0 : octet_value;
  // value * 10 + digit
  assign octet_acc   = {1'b0, mul_src, 3'b000} + {3'b000, mul_src, 1'b0} +
                       {8'd0, q_word.digit};
  assign octet_over  = octet_acc > 12'(ipv6lv_pkg::OCTET_MAX);

  always_comb begin
    phase_next               = phase;
    failed_next              = failed;
    group_count_next         = group_count;
    compression_seen_next    = compression_seen;
    leading_colons_next      = leading_colons;
    pending_colon_next       = pending_colon;
    hex_digit_count_next     = hex_digit_count;
    segment_all_decimal_next = segment_all_decimal;
    octet_value_next         = octet_value;
    octet_digit_count_next   = octet_digit_count;
    octet_leading_zero_next  = octet_leading_zero;
    octet_index_next         = octet_index;

    if (!failed) begin
      if (phase == ipv6lv_pkg::PH_START) begin
        if (leading_colons == 2'd0) begin
          if (q_word.cls == ipv6lv_pkg::CC_COLON) begin
            leading_colons_next = 2'd1;
          end else begin
            phase_next = ipv6lv_pkg::PH_HEX;
          end
        end else if (q_word.cls == ipv6lv_pkg::CC_COLON) begin
          leading_colons_next   = 2'd2;
          compression_seen_next = 1'b1;
          phase_next            = ipv6lv_pkg::PH_HEX;
        end else begin
          failed_next = 1'b1;
        end
      end

      if (hex_step) begin
        if (is_hex) begin
          if (group_start && group_count >= 4'(ipv6lv_pkg::MAX_GROUPS)) begin
            failed_next = 1'b1;
          end else if (hex_digit_count >= 3'(ipv6lv_pkg::GROUP_DIGITS)) begin
            failed_next = 1'b1;
          end else begin
            if (group_start) begin
              segment_all_decimal_next = 1'b1;
              octet_value_next         = '0;
              octet_digit_count_next   = '0;
              octet_leading_zero_next  = 1'b0;
            end
            if (q_word.cls == ipv6lv_pkg::CC_DIGIT && (group_start || segment_all_decimal)) begin
              if (group_start || octet_digit_count == 2'd0) begin
                octet_value_next        = octet_acc[7:0];
                octet_digit_count_next  = 2'd1;
                octet_leading_zero_next = q_word.digit == 4'd0;
              end else if (octet_leading_zero || octet_over ||
                           octet_digit_count >= 2'(ipv6lv_pkg::OCTET_DIGITS)) begin
                segment_all_decimal_next = 1'b0;
              end else begin
                octet_value_next       = octet_acc[7:0];
                octet_digit_count_next = octet_digit_count + 1'b1;
              end
            end else begin
              segment_all_decimal_next = 1'b0;
            end
            hex_digit_count_next = hex_digit_count + 1'b1;
            pending_colon_next   = 1'b0;
          end
        end else if (q_word.cls == ipv6lv_pkg::CC_COLON) begin
          if (hex_digit_count != 3'd0) begin
            if (group_count != 4'(ipv6lv_pkg::GROUP_SAT)) begin
              group_count_next = group_count + 1'b1;
            end
            hex_digit_count_next = '0;
            pending_colon_next   = 1'b1;
          end else if (pending_colon && !compression_seen) begin
            compression_seen_next = 1'b1;
            pending_colon_next    = 1'b0;
          end else begin
            failed_next = 1'b1;
          end
        end else if (q_word.cls == ipv6lv_pkg::CC_DOT) begin
          if (hex_digit_count != 3'd0 && segment_all_decimal) begin
            phase_next              = ipv6lv_pkg::PH_IPV4;
            octet_index_next        = 2'd1;
            octet_value_next        = '0;
            octet_digit_count_next  = '0;
            octet_leading_zero_next = 1'b0;
          end else begin
            failed_next = 1'b1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end else if (phase == ipv6lv_pkg::PH_IPV4) begin
        if (q_word.cls == ipv6lv_pkg::CC_DIGIT) begin
          if (octet_digit_count >= 2'(ipv6lv_pkg::OCTET_DIGITS) || octet_leading_zero ||
              octet_over) begin
            failed_next = 1'b1;
          end else begin
            if (octet_digit_count == 2'd0) begin
              octet_leading_zero_next = q_word.digit == 4'd0;
            end
            octet_value_next       = octet_acc[7:0];
            octet_digit_count_next = octet_digit_count + 1'b1;
          end
        end else if (q_word.cls == ipv6lv_pkg::CC_DOT) begin
          if (octet_digit_count == 2'd0 ||
              octet_index >= 2'(ipv6lv_pkg::IPV4_OCTETS)) begin
            failed_next = 1'b1;
          end else begin
            octet_index_next        = octet_index + 1'b1;
            octet_value_next        = '0;
            octet_digit_count_next  = '0;
            octet_leading_zero_next = 1'b0;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  // verdict on the state after this word
  always_comb begin
    groups  = {1'b0, group_count_next};
    verdict = 1'b0;
    unique case (phase_next)
      ipv6lv_pkg::PH_HEX: begin
        if (hex_digit_count_next != 3'd0) begin
          groups = groups + 5'd1;
        end
        verdict = !pending_colon_next;
      end
      ipv6lv_pkg::PH_IPV4: begin
        groups  = groups + 5'd2;
        verdict = octet_index_next == 2'(ipv6lv_pkg::IPV4_OCTETS) &&
                  octet_digit_count_next != 2'd0;
      end
      default: begin
        verdict = 1'b0;
      end
    endcase
    if (compression_seen_next) begin
      verdict = verdict && groups < 5'(ipv6lv_pkg::MAX_GROUPS);
    end else begin
      verdict = verdict && groups == 5'(ipv6lv_pkg::MAX_GROUPS);
    end
    verdict = verdict && !failed_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && q_word.last)) begin
      phase               <= ipv6lv_pkg::PH_START;
      failed              <= 1'b0;
      group_count         <= '0;
      compression_seen    <= 1'b0;
      leading_colons      <= '0;
      pending_colon       <= 1'b0;
      hex_digit_count     <= '0;
      segment_all_decimal <= 1'b1;
      octet_value         <= '0;
      octet_digit_count   <= '0;
      octet_leading_zero  <= 1'b0;
      octet_index         <= '0;
    end else if (pop) begin
      phase               <= phase_next;
      failed              <= failed_next;
      group_count         <= group_count_next;
      compression_seen    <= compression_seen_next;
      leading_colons      <= leading_colons_next;
      pending_colon       <= pending_colon_next;
      hex_digit_count     <= hex_digit_count_next;
      segment_all_decimal <= segment_all_decimal_next;
      octet_value         <= octet_value_next;
      octet_digit_count   <= octet_digit_count_next;
      octet_leading_zero  <= octet_leading_zero_next;
      octet_index         <= octet_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_word.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_word.last) begin
      literal_valid <= verdict;
    end
  end

endmodule

### rtl/core/ipv6_literal_validator.sv
// path of a final byte: classify register, queue, parser and verdict register
// throughput: one byte per cycle while verdicts are taken; parser pops one word per cycle
// a final word waits in the queue only while the previous verdict is not yet taken
// reset: rst is synchronous, active high; parser returns to start of literal, queue empties
module ipv6_literal_validator #(
  parameter int QueueDepth = ipv6lv_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] byte_value,
  input  logic       last_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       literal_valid,
  output logic       out_valid,
  input  logic       out_ready
);

  logic                            f_valid;
  logic                            f_ready;
  ipv6lv_pkg::word_t               f_word;
  logic                            q_valid;
  logic                            q_ready;
  ipv6lv_pkg::word_t               q_word;
  logic [$clog2(QueueDepth+1)-1:0] q_count;

  ipv6lv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .f_valid    (f_valid),
    .f_ready    (f_ready),
    .f_word     (f_word)
  );

  ipv6lv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word),
    .count      (q_count)
  );

  ipv6lv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_word        (q_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .literal_valid (literal_valid)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
    else $error("queue occupancy above depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> q_count == '0 && !out_valid && !f_valid)
    else $error("pipeline not empty after reset");

  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(q_valid && q_ready && q_word.last))
    else $error("verdict without a final word");

  a_last_blocked: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_word.last && out_valid && !out_ready |-> !q_ready)
    else $error("final word popped over a pending verdict");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_DOT = ".";
  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_BYTES = 1550;

  typedef struct {
    logic [7:0] value;
    bit last;
    bit drain;
  } text_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [7:0] byte_value = 8'h00;
  logic last_byte = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic literal_valid;
  logic out_valid;
  logic out_ready = 1'b0;

  text_byte_t text_bytes[$];
  bit verdicts_due[$];
  int verdicts_made;
  int verdicts_seen;
  int valid_seen;
  int mismatches;
  int send_gap;
  int hold_gap;
  int quiet;
  int unsigned cyc;
  string hex_chars = "0123456789abcdefABCDEF";
  string noise_chars = ":.09afAFgG/@~";

  // parser state
  ipv6lv_pkg::phase_t ph;
  bit failed;
  logic [3:0] grp_cnt;
  bit compressed;
  logic [1:0] lead_colons;
  bit colon_open;
  logic [2:0] hex_cnt;
  bit dec_group;
  logic [7:0] oct_val;
  logic [1:0] oct_digits;
  bit oct_zero;
  logic [1:0] oct_idx;

  always #4 clk = ~clk;

  ipv6_literal_validator dut (
    .clk(clk),
    .rst(rst),
    .byte_value(byte_value),
    .last_byte(last_byte),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .literal_valid(literal_valid),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  function automatic void octet_clear();
    oct_val = 8'd0;
    oct_digits = 2'd0;
    oct_zero = 1'b0;
  endfunction

  function automatic void parse_reset();
    ph = ipv6lv_pkg::PH_START;
    failed = 1'b0;
    grp_cnt = 4'd0;
    compressed = 1'b0;
    lead_colons = 2'd0;
    colon_open = 1'b0;
    hex_cnt = 3'd0;
    dec_group = 1'b1;
    octet_clear();
    oct_idx = 2'd0;
  endfunction

  function automatic void hex_char(logic [7:0] b);
    bit is_dec;
    bit is_hex;
    int d;
    int nv;
    is_dec = (b >= "0" && b <= "9");
    is_hex = is_dec || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    d = int'(b) - int'("0");
    nv = int'(oct_val) * 10 + d;
    if (is_hex) begin
      if (hex_cnt == 0) begin
        if (grp_cnt >= ipv6lv_pkg::MAX_GROUPS) begin
          failed = 1'b1;
          return;
        end
        dec_group = 1'b1;
        octet_clear();
      end
      if (hex_cnt >= ipv6lv_pkg::GROUP_DIGITS) begin
        failed = 1'b1;
        return;
      end
      if (is_dec && dec_group) begin
        if (oct_digits == 0) begin
          oct_val = 8'(d);
          oct_digits = 2'd1;
          oct_zero = (d == 0);
        end else if (oct_zero || oct_digits >= ipv6lv_pkg::OCTET_DIGITS ||
                     nv > ipv6lv_pkg::OCTET_MAX) begin
          dec_group = 1'b0;
        end else begin
          oct_val = 8'(nv);
          oct_digits = oct_digits + 2'd1;
        end
      end else begin
        dec_group = 1'b0;
      end
      hex_cnt = hex_cnt + 3'd1;
      colon_open = 1'b0;
    end else if (b == CH_COLON) begin
      if (hex_cnt > 0) begin
        if (grp_cnt < ipv6lv_pkg::GROUP_SAT) grp_cnt = grp_cnt + 4'd1;
        hex_cnt = 3'd0;
        colon_open = 1'b1;
      end else if (colon_open) begin
        if (compressed) begin
          failed = 1'b1;
          return;
        end
        compressed = 1'b1;
        colon_open = 1'b0;
      end else begin
        failed = 1'b1;
      end
    end else if (b == CH_DOT) begin
      if (hex_cnt > 0 && dec_group) begin
        ph = ipv6lv_pkg::PH_IPV4;
        oct_idx = 2'd1;
        octet_clear();
      end else begin
        failed = 1'b1;
      end
    end else begin
      failed = 1'b1;
    end
  endfunction

  function automatic void quad_char(logic [7:0] b);
    int d;
    int nv;
    d = int'(b) - int'("0");
    nv = int'(oct_val) * 10 + d;
    if (b >= "0" && b <= "9") begin
      if (oct_digits >= ipv6lv_pkg::OCTET_DIGITS || oct_zero ||
          nv > ipv6lv_pkg::OCTET_MAX) begin
        failed = 1'b1;
        return;
      end
      if (oct_digits == 0) oct_zero = (d == 0);
      oct_val = 8'(nv);
      oct_digits = oct_digits + 2'd1;
    end else if (b == CH_DOT) begin
      if (oct_digits == 0 || oct_idx >= ipv6lv_pkg::IPV4_OCTETS) begin
        failed = 1'b1;
        return;
      end
      oct_idx = oct_idx + 2'd1;
      octet_clear();
    end else begin
      failed = 1'b1;
    end
  endfunction

  function automatic void scan_char(logic [7:0] b);
    if (failed) return;
    case (ph)
      ipv6lv_pkg::PH_START: begin
        if (lead_colons == 0) begin
          if (b == CH_COLON) begin
            lead_colons = 2'd1;
          end else begin
            ph = ipv6lv_pkg::PH_HEX;
            hex_char(b);
          end
        end else if (b == CH_COLON) begin
          lead_colons = 2'd2;
          compressed = 1'b1;
          ph = ipv6lv_pkg::PH_HEX;
        end else begin
          failed = 1'b1;
        end
      end
      ipv6lv_pkg::PH_HEX: hex_char(b);
      ipv6lv_pkg::PH_IPV4: quad_char(b);
      default: failed = 1'b1;
    endcase
  endfunction

  function automatic bit literal_verdict();
    int groups;
    groups = grp_cnt;
    if (failed) return 1'b0;
    case (ph)
      ipv6lv_pkg::PH_HEX: begin
        if (colon_open) return 1'b0;
        if (hex_cnt > 0) groups++;
      end
      ipv6lv_pkg::PH_IPV4: begin
        if (oct_idx != ipv6lv_pkg::IPV4_OCTETS || oct_digits == 0) return 1'b0;
        groups += 2;
      end
      default: return 1'b0;
    endcase
    return compressed ? (groups < ipv6lv_pkg::MAX_GROUPS) :
                        (groups == ipv6lv_pkg::MAX_GROUPS);
  endfunction

  function automatic int idle_len();
    int r;
    if ((cyc / 700) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_literal(string s, bit drain);
    for (int i = 0; i < s.len(); i++) begin
      text_bytes.push_back('{s[i], i == s.len() - 1, drain && i == 0});
    end
  endfunction

  function automatic string hex_group();
    string g;
    int n;
    int k;
    bit decimal_only;
    g = "";
    n = $urandom_range(1, ipv6lv_pkg::GROUP_DIGITS);
    if ($urandom_range(0, 19) == 0) n = ipv6lv_pkg::GROUP_DIGITS + 1;
    decimal_only = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      k = decimal_only ? $urandom_range(0, 9) : $urandom_range(0, hex_chars.len() - 1);
      g = {g, hex_chars.substr(k, k)};
    end
    return g;
  endfunction

  function automatic string octet_text();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $sformatf("%0d", $urandom_range(0, 255));
    if (r == 7) return $sformatf("0%0d", $urandom_range(0, 99));
    if (r == 8) return $sformatf("%0d", $urandom_range(256, 999));
    return $urandom_range(0, 1) ? "255" : "";
  endfunction

  function automatic string well_formed();
    string toks[$];
    string s;
    bit squeezed;
    bit tail;
    int n;
    int p;
    int octets;
    squeezed = ($urandom_range(0, 2) != 0);
    tail = ($urandom_range(0, 3) == 0);
    n = tail ? ipv6lv_pkg::MAX_GROUPS - 2 : ipv6lv_pkg::MAX_GROUPS;
    if (squeezed) n = $urandom_range(0, n - 1);
    if ($urandom_range(0, 9) == 0) n = n + 1;
    else if ($urandom_range(0, 9) == 0 && n > 0) n = n - 1;
    for (int i = 0; i < n; i++) toks.push_back(hex_group());
    if (tail) begin
      octets = 4;
      if ($urandom_range(0, 9) == 0) octets = $urandom_range(0, 1) ? 3 : 5;
      s = octet_text();
      for (int j = 1; j < octets; j++) s = {s, ".", octet_text()};
      toks.push_back(s);
    end
    p = $urandom_range(0, n);
    if (squeezed) toks.insert(p, "");
    s = "";
    foreach (toks[i]) begin
      if (i > 0) s = {s, ":"};
      s = {s, toks[i]};
    end
    if (squeezed && p == 0) s = {":", s};
    if (squeezed && p == toks.size() - 1) s = {s, ":"};
    return s;
  endfunction

  function automatic string mutate(string s);
    string c;
    int pos;
    int k;
    pos = $urandom_range(0, s.len() - 1);
    if ($urandom_range(0, 1)) begin
      k = $urandom_range(0, noise_chars.len() - 1);
      c = noise_chars.substr(k, k);
    end else begin
      c = $sformatf("%c", 8'($urandom_range(1, 255)));
    end
    case ($urandom_range(0, 2))
      0: return {s.substr(0, pos - 1), c, s.substr(pos + 1, s.len() - 1)};
      1: if (s.len() > 1) return {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
      default: ;
    endcase
    return {s.substr(0, pos - 1), c, s.substr(pos, s.len() - 1)};
  endfunction

  // driver, with the prediction made as each word is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      parse_reset();
      verdicts_made = 0;
    end else begin
      if (in_valid && in_ready) begin
        scan_char(byte_value);
        if (last_byte) begin
          verdicts_due.push_back(literal_verdict());
          parse_reset();
          verdicts_made++;
        end
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (text_bytes.size() > 0 &&
                     !(text_bytes[0].drain && verdicts_made != verdicts_seen)) begin
          in_valid <= 1'b1;
          byte_value <= text_bytes[0].value;
          last_byte <= text_bytes[0].last;
          text_bytes.delete(0);
          send_gap <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_gap <= 0;
      verdicts_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict with none pending, expected none, got %0b", $time,
                   literal_valid);
          mismatches++;
        end else begin
          if (verdicts_due[0] !== literal_valid) begin
            $display("%0t: verdict mismatch, expected %0b, got %0b", $time,
                     verdicts_due[0], literal_valid);
            mismatches++;
          end
          if (verdicts_due[0]) valid_seen++;
          verdicts_due.delete(0);
        end
        verdicts_seen <= verdicts_seen + 1;
      end
      if (hold_gap > 0) begin
        hold_gap <= hold_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) hold_gap <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int directed;
    int r;
    int len;
    bit drain;
    logic [7:0] b;
    // compression alone, single leading colon, trailing single colon,
    // dot after a non-decimal group, ipv4 tail, byte extremes
    add_literal("::", 1'b0);
    add_literal(":a", 1'b0);
    add_literal("F:", 1'b0);
    add_literal("a.1", 1'b0);
    add_literal("::1.2.3.4", 1'b0);
    text_bytes.push_back('{8'hff, 1'b1, 1'b0});
    text_bytes.push_back('{8'h00, 1'b1, 1'b0});
    directed = text_bytes.size();
    drain = 1'b1;
    while (text_bytes.size() < directed + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add_literal(well_formed(), drain);
      end else if (r < 85) begin
        add_literal(mutate(well_formed()), drain);
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 1)) b = 8'($urandom_range(0, 255));
          else b = noise_chars[$urandom_range(0, noise_chars.len() - 1)];
          text_bytes.push_back('{b, i == len - 1, drain && i == 0});
        end
      end
      drain = ($urandom_range(0, 14) == 0);
    end
    len = text_bytes.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (text_bytes.size() != 0 || in_valid) @(negedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("sent %0d bytes as %0d literals (directed and random, with and without idling)",
             len, verdicts_made);
    $display("%0d literals judged valid, %0d judged invalid", valid_seen,
             verdicts_made - valid_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
